### hdl/pcvma_pkg.sv
// shared types and constants of the per-cell velocity moment accumulator
// used by pcvma_ctrl, pcvma_datapath and the top level; no dependencies
package pcvma_pkg;

    // fixed field widths of the stream beats
    localparam int CELL_REQ_W  = 10;
    localparam int VEL_FIELD_W = 16;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 48;
    localparam int SQ_W        = 56;
    localparam int LANES       = 3;

    // input tdata layout: cell_req, vel_u, vel_v, vel_w from bit 0 up
    localparam int CELL_LSB    = 0;
    localparam int VEL_LSB     = CELL_LSB + CELL_REQ_W;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;

    // kind codes carried in s_axis_tuser
    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // one cell row: count lowest, then the three sums, then the three square sums
    typedef struct packed {
        logic [LANES-1:0][SQ_W-1:0]  sq;
        logic [LANES-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]            cnt;
    } cell_row_t;

    localparam int OUT_TDATA_W = $bits(cell_row_t);

    // controller to datapath
    typedef struct packed {
        logic clear;   // write zeros at the sweep address, advance the sweep
        logic load;    // capture the accepted input beat
        logic fetch;   // read the cell row, form the squares
        logic update;  // write back the new row, load the result register on a read
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // sweep is at the last row
        logic is_read;   // captured item is a read
    } dp_stat_t;

endpackage

### hdl/pcvma_ctrl.sv
// control state machine of the per-cell velocity moment accumulator
// depends on pcvma_pkg; drives pcvma_datapath through dp_cmd_t
module pcvma_ctrl
    import pcvma_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    output logic     m_axis_tvalid,
    input  logic     m_axis_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_finish;

    // a read may only finish once the result register is free or draining
    assign can_finish = !stat.is_read || !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (can_finish)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update && stat.is_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

endmodule

### hdl/pcvma_datapath.sv
// datapath of the per-cell velocity moment accumulator: cell row memory,
// squarers, saturating adders and result register; depends on pcvma_pkg
module pcvma_datapath
    import pcvma_pkg::*;
#(
    parameter int CELL_COUNT = 1024,
    parameter int VEL_BITS   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int PROD_W = 2 * VEL_BITS;

    // cell row memory, one row per cell
    cell_row_t mem [CELL_COUNT];

    logic [CELL_W-1:0]        clr_reg;
    logic [CELL_REQ_W-1:0]    cell_reg;
    logic                     kind_reg;
    logic                     in_range_reg;
    logic [VEL_BITS-1:0]      vel_reg [LANES];
    logic [PROD_W-1:0]        sq_reg  [LANES];
    cell_row_t                rd_reg;
    cell_row_t                out_reg;
    cell_row_t                acc_row;
    logic [CELL_W-1:0]        addr;
    logic [CELL_REQ_W-1:0]    cell_in;
    logic                     we;
    logic [CELL_W-1:0]        waddr;
    cell_row_t                wdata;

    assign cell_in = s_axis_tdata[CELL_LSB +: CELL_REQ_W];
    assign addr    = CELL_W'(cell_reg);

    // capture of the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cell_reg     <= cell_in;
            kind_reg     <= s_axis_tuser[0];
            in_range_reg <= (32'(cell_in) < CELL_COUNT);
            for (int k = 0; k < LANES; k++)
            begin
                vel_reg[k] <= VEL_BITS'(s_axis_tdata[VEL_LSB + k*VEL_FIELD_W +: VEL_FIELD_W]);
            end
        end
    end

    // fetch: row read and squares, both registered
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rd_reg <= mem[addr];
            for (int k = 0; k < LANES; k++)
            begin
                sq_reg[k] <= PROD_W'($signed(vel_reg[k]) * $signed(vel_reg[k]));
            end
        end
    end

    // saturating accumulate of one particle into the fetched row
    always_comb
    begin
        logic signed [SUM_W:0] s_ext;
        logic [SQ_W:0]         q_ext;
        acc_row     = rd_reg;
        acc_row.cnt = (&rd_reg.cnt) ? rd_reg.cnt : rd_reg.cnt + 1'b1;
        for (int k = 0; k < LANES; k++)
        begin
            s_ext = $signed({rd_reg.sum[k][SUM_W-1], rd_reg.sum[k]})
                  + (SUM_W+1)'($signed(vel_reg[k]));
            if (s_ext[SUM_W] != s_ext[SUM_W-1])
            begin
                acc_row.sum[k] = s_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                              : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                acc_row.sum[k] = s_ext[SUM_W-1:0];
            end
            q_ext = {1'b0, rd_reg.sq[k]} + (SQ_W+1)'(sq_reg[k]);
            acc_row.sq[k] = q_ext[SQ_W] ? {SQ_W{1'b1}} : q_ext[SQ_W-1:0];
        end
    end

    // single write port: clearing sweep or write-back
    always_comb
    begin
        we    = 1'b0;
        waddr = addr;
        wdata = '0;
        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = clr_reg;
        end
        else if (cmd.update && in_range_reg)
        begin
            we    = 1'b1;
            wdata = (kind_reg == KIND_READ) ? cell_row_t'('0) : acc_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && (kind_reg == KIND_READ))
        begin
            out_reg <= in_range_reg ? rd_reg : cell_row_t'('0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign stat.clr_last = (clr_reg == CELL_W'(CELL_COUNT - 1));
    assign stat.is_read  = (kind_reg == KIND_READ);
    assign m_axis_tdata  = out_reg;

endmodule

### hdl/per_cell_velocity_moment_accumulator.sv
// per-cell velocity moment accumulator: each item passes the accept, fetch-and-square and
// write-back steps on the cell row memory (one row read, one row write); a new item is
// accepted only after the previous one is written back; a read loads the result register
// at write-back, and waits there while the previous result beat is still unaccepted
// reset is asynchronous, active low; afterwards a clearing pass writes zeros to every
// row, during which s_axis_tready stays low
module per_cell_velocity_moment_accumulator
    import pcvma_pkg::*;
#(
    parameter int CELL_COUNT = 1024,  // cells held, 2 .. 1024
    parameter int VEL_BITS   = 16     // velocity bits used, 8 .. 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cell_req[9:0], vel_u[25:10], vel_v[41:26], vel_w[57:42], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]: 0 accumulate, 1 read and clear
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // particle_count[31:0], sum_u[79:32], sum_v[127:80], sum_w[175:128],
    // sum_usq[231:176], sum_vsq[287:232], sum_wsq[343:288]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: clearing sweep, then accept / fetch / update per beat
    pcvma_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // row memory, squarers, saturating adders and result register
    pcvma_datapath #(
        .CELL_COUNT (CELL_COUNT),
        .VEL_BITS   (VEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata)
    );

    // no beat is taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear && s_axis_tready))
        else $error("input ready during clearing pass");

    // a captured beat is always followed by its row fetch
    a_load_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.fetch)
        else $error("fetch did not follow load");

    // a finished read always presents its result beat
    a_read_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && stat.is_read) |=> m_axis_tvalid)
        else $error("read finished without result beat");

    // at most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.fetch, cmd.update}))
        else $error("overlapping datapath commands");

endmodule

### test/tb_per_cell_velocity_moment_accumulator.sv
// testbench for per_cell_velocity_moment_accumulator: streams particle and readout beats,
// predicts the per-cell count, velocity sums and square sums, checks every result beat
// depends on pcvma_pkg and the accumulator rtl only
`timescale 1ns / 100ps

module tb_per_cell_velocity_moment_accumulator;
    import pcvma_pkg::*;

    localparam int          CELLS        = 1024;
    localparam int          VBITS        = 16;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          ERR_PRINTS   = 40;
    localparam longint      VSUM_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      VSUM_MIN     = -VSUM_MAX - 1;
    localparam longint unsigned SQ_LIMIT = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [31:0] COUNT_LIMIT  = 32'hFFFF_FFFF;

    // one input beat: kind on tuser, cell and the three velocities (u lowest) on tdata
    typedef struct packed {
        logic                                kind;
        logic [LANES-1:0][VEL_FIELD_W-1:0]   vel;
        logic [CELL_REQ_W-1:0]               cell_idx;
    } particle_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shared between the stimulus and the receiver
    int          cycle_no   = 0;
    int          err_count  = 0;
    logic        idle_on    = 1'b0;
    logic        hold_tog   = 1'b0;
    logic        hold_seen  = 1'b0;
    int          rx_hold    = 0;
    int          rx_gap     = 0;
    logic [CELL_REQ_W-1:0] hot_cells [8];

    // predicted per-cell moments
    logic [CNT_W-1:0] count_mem [CELLS];
    longint           vsum_mem  [CELLS][LANES];
    longint unsigned  sq_mem    [CELLS][LANES];
    cell_row_t        expected_rows [$];

    string lane_tag [LANES] = '{"u", "v", "w"};

    per_cell_velocity_moment_accumulator #(
        .CELL_COUNT (CELLS),
        .VEL_BITS   (VBITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // watchdog, counts cycles from time zero including the clearing pass
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_no);
            $display("per_cell_velocity_moment_accumulator: mismatch");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // velocity field: extremes and signs near zero get extra weight
    function automatic logic [VEL_FIELD_W-1:0] pick_vel();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return VEL_FIELD_W'($urandom);
        endcase
    endfunction

    // signed value of the low VBITS bits of a velocity field
    function automatic longint vel_value(logic [VEL_FIELD_W-1:0] raw);
        longint t;
        t = longint'({48'h0, raw});
        t = t << (64 - VBITS);
        return t >>> (64 - VBITS);
    endfunction

    // update the predicted cell, queue the expected row on a readout
    function automatic void predict_moments(particle_beat_t b);
        cell_row_t       row;
        longint          v;
        longint          s;
        longint unsigned q;
        int              idx;
        idx = int'(b.cell_idx);
        if (b.kind == KIND_ACCUM)
        begin
            // out-of-range accumulate leaves every cell alone
            if (idx < CELLS)
            begin
                if (count_mem[idx] != COUNT_LIMIT)
                    count_mem[idx] = count_mem[idx] + 1;
                for (int k = 0; k < LANES; k++)
                begin
                    v = vel_value(b.vel[k]);
                    s = vsum_mem[idx][k] + v;
                    if (s > VSUM_MAX)
                        s = VSUM_MAX;
                    else if (s < VSUM_MIN)
                        s = VSUM_MIN;
                    vsum_mem[idx][k] = s;
                    q = sq_mem[idx][k] + longint'(v * v);
                    sq_mem[idx][k] = (q > SQ_LIMIT) ? SQ_LIMIT : q;
                end
            end
        end
        else
        begin
            // out-of-range readout returns an all-zero row
            row = '0;
            if (idx < CELLS)
            begin
                row.cnt = count_mem[idx];
                count_mem[idx] = '0;
                for (int k = 0; k < LANES; k++)
                begin
                    row.sum[k] = vsum_mem[idx][k][SUM_W-1:0];
                    row.sq[k]  = sq_mem[idx][k][SQ_W-1:0];
                    vsum_mem[idx][k] = 0;
                    sq_mem[idx][k]   = 0;
                end
            end
            expected_rows.push_back(row);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= ERR_PRINTS)
            $display("ERROR cycle %0d: %s is %h, expected %h", cycle_no, what, got, want);
    endtask

    // offer one beat, optionally after an idle gap; predict once it is taken
    task automatic send_beat(input particle_beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - CELL_REQ_W - LANES * VEL_FIELD_W){1'b0}}, b.vel,
                          b.cell_idx};
        s_axis_tuser  <= b.kind;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predict_moments(b);
    endtask

    function automatic particle_beat_t make_beat(input logic kind, input int cell_no,
                                                 input int u, input int v, input int w);
        particle_beat_t b;
        b.kind     = kind;
        b.cell_idx = CELL_REQ_W'(cell_no);
        b.vel[0]   = VEL_FIELD_W'(u);
        b.vel[1]   = VEL_FIELD_W'(v);
        b.vel[2]   = VEL_FIELD_W'(w);
        return b;
    endfunction

    // random beat: read_pct percent readouts, hot_pct percent on the hot cell set
    function automatic particle_beat_t random_beat(input int read_pct, input int hot_pct,
                                                   input int hot_n);
        particle_beat_t b;
        b.kind = ($urandom_range(0, 99) < read_pct) ? KIND_READ : KIND_ACCUM;
        if ($urandom_range(0, 99) < hot_pct)
            b.cell_idx = hot_cells[$urandom_range(0, hot_n - 1)];
        else
            b.cell_idx = CELL_REQ_W'($urandom);
        for (int k = 0; k < LANES; k++)
            b.vel[k] = pick_vel();
        return b;
    endfunction

    task automatic pick_hot_cells();
        for (int i = 0; i < 8; i++)
            hot_cells[i] = CELL_REQ_W'($urandom);
        // the index extremes show up in some of the sets
        if ($urandom_range(0, 1) == 1)
            hot_cells[0] = '0;
        if ($urandom_range(0, 1) == 1)
            hot_cells[1] = CELL_REQ_W'(CELLS - 1);
    endtask

    // receiver: random stalls, plus a long hold-off when the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen     <= hold_tog;
            rx_hold       <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap        <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                rx_gap <= pick_gap();
        end
    end

    // compare each result beat, field by field, with the oldest expected row
    always @(posedge clk)
    begin
        cell_row_t got;
        cell_row_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_rows.size() == 0)
                report_mismatch("result beat with none pending", 64'(got.cnt), '0);
            else
            begin
                want = expected_rows.pop_front();
                if (got.cnt !== want.cnt)
                    report_mismatch("particle_count", 64'(got.cnt), 64'(want.cnt));
                for (int k = 0; k < LANES; k++)
                begin
                    if (got.sum[k] !== want.sum[k])
                        report_mismatch({"sum_", lane_tag[k]}, 64'(got.sum[k]),
                                        64'(want.sum[k]));
                    if (got.sq[k] !== want.sq[k])
                        report_mismatch({"sum_", lane_tag[k], "sq"}, 64'(got.sq[k]),
                                        64'(want.sq[k]));
                end
            end
        end
    end

    // extremes of every field, both kinds, readout of fresh and just-cleared cells
    task automatic test_directed();
        idle_on = 1'b0;
        send_beat(make_beat(KIND_READ, 0, 0, 0, 0));
        send_beat(make_beat(KIND_ACCUM, 0, -32768, 32767, 0));
        send_beat(make_beat(KIND_ACCUM, 0, 32767, -32768, -1));
        send_beat(make_beat(KIND_ACCUM, 0, -32768, -32768, -32768));
        send_beat(make_beat(KIND_READ, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_beat(KIND_READ, 0, 0, 0, 0));
        send_beat(make_beat(KIND_ACCUM, CELLS - 1, 16'hAAAA, 16'h5555, 16'hFFFF));
        send_beat(make_beat(KIND_ACCUM, CELLS - 1, 16'h5555, 16'hAAAA, 16'h0001));
        send_beat(make_beat(KIND_ACCUM, 1023, 32767, 32767, 32767));
        send_beat(make_beat(KIND_READ, 1023, 0, 0, 0));
        send_beat(make_beat(KIND_READ, 512, 0, 0, 0));
        // same cell back to back, then readout right behind, then reuse after clear
        send_beat(make_beat(KIND_ACCUM, 5, 256, -256, 1));
        send_beat(make_beat(KIND_ACCUM, 5, 256, -256, 1));
        send_beat(make_beat(KIND_ACCUM, 5, -1, 1, -32768));
        send_beat(make_beat(KIND_READ, 5, 0, 0, 0));
        send_beat(make_beat(KIND_ACCUM, 5, 100, 200, 300));
        send_beat(make_beat(KIND_READ, 5, 0, 0, 0));
        send_beat(make_beat(KIND_ACCUM, 6, 7, 8, 9));
        send_beat(make_beat(KIND_ACCUM, 5, 1, 2, 3));
        send_beat(make_beat(KIND_READ, 6, 0, 0, 0));
        send_beat(make_beat(KIND_READ, 5, 0, 0, 0));
    endtask

    // dense traffic on three cells, no gaps: beats keep returning to the same rows
    task automatic test_same_cell_traffic();
        idle_on = 1'b0;
        pick_hot_cells();
        for (int i = 0; i < 150; i++)
            send_beat(random_beat(25, 100, 3));
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        idle_on = 1'b0;
        pick_hot_cells();
        hold_tog <= ~hold_tog;
        for (int i = 0; i < 60; i++)
            send_beat(random_beat(35, 90, 4));
    endtask

    // random mix in segments, gaps switched on and off between segments
    task automatic test_random_mix();
        for (int seg = 0; seg < 6; seg++)
        begin
            idle_on = (seg % 3 != 2);
            pick_hot_cells();
            for (int i = 0; i < 255; i++)
                send_beat(random_beat(20, 80, 8));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (int c = 0; c < CELLS; c++)
        begin
            count_mem[c] = '0;
            for (int k = 0; k < LANES; k++)
            begin
                vsum_mem[c][k] = 0;
                sq_mem[c][k]   = 0;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // input readiness after the clearing pass is found by the handshake itself
        @(posedge clk);
        test_directed();
        test_same_cell_traffic();
        test_backpressure();
        test_random_mix();
        s_axis_tvalid <= 1'b0;
        idle_on = 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("per_cell_velocity_moment_accumulator: match");
        else
            $display("per_cell_velocity_moment_accumulator: mismatch");
        $finish;
    end

endmodule

### files.f
hdl/pcvma_pkg.sv
hdl/pcvma_ctrl.sv
hdl/pcvma_datapath.sv
hdl/per_cell_velocity_moment_accumulator.sv
test/tb_per_cell_velocity_moment_accumulator.sv
